// ===== hdl/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Shared constants, types and decode helpers for the parser.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  localparam logic [7:0] STATUS_NONE     = 8'h00;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
  localparam logic [7:0] STATUS_RT_FIRST = 8'hF8;
  localparam logic [3:0] KIND_PROG       = 4'hC;
  localparam logic [3:0] KIND_PRESSURE   = 4'hD;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam logic signed [4:0] FILTER_ALL = -5'sd1;

  // Parser state carried from beat to beat
  typedef struct packed {
    logic [7:0] running_status;
    logic       data_count;
    logic [6:0] first_data;
  } state_t;

  // One assembled message
  typedef struct packed {
    logic       valid;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [1:0] length;
    logic       accepted;
  } msg_t;

  // Data bytes that a status needs: 0, 1 or 2
  function automatic logic [1:0] data_needed(input logic [7:0] status);
    logic [1:0] need;
    begin
      need = 2'd0;
      if (status == STATUS_SONG_POS) begin
        need = 2'd2;
      end else if (status[7:4] == KIND_PROG || status[7:4] == KIND_PRESSURE) begin
        need = 2'd1;
      end else if (status[7] && status[7:4] != 4'hF) begin
        need = 2'd2;
      end
      return need;
    end
  endfunction

  function automatic logic chan_accepts(input logic [7:0] status,
                                        input logic signed [4:0] filter);
    return (status >= STATUS_SYSEX) || (filter == FILTER_ALL) ||
           (!filter[4] && filter[3:0] == status[3:0]);
  endfunction

endpackage

// ===== hdl/mrsp_decode.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status decoder
// Classifies one received byte against the current state and gives the
// next state and the message it completes, if any.
// ----------------------------------------------------------------------------
module mrsp_decode (
  input  logic [7:0]        rx_byte,
  input  mrsp_pkg::state_t  state,
  input  logic signed [4:0] filter,
  output mrsp_pkg::state_t  state_next,
  output mrsp_pkg::msg_t    msg
);

  logic [1:0] need;

  assign need = mrsp_pkg::data_needed(state.running_status);

  always_comb begin
    state_next   = state;
    msg.valid    = 1'b0;
    msg.status   = state.running_status;
    msg.data1    = 7'd0;
    msg.data2    = 7'd0;
    msg.length   = mrsp_pkg::LEN_ONE;
    msg.accepted = 1'b0;

    if (rx_byte >= mrsp_pkg::STATUS_RT_FIRST) begin
      // realtime: pass straight out, leave the assembly alone
      msg.valid  = 1'b1;
      msg.status = rx_byte;
    end else if (rx_byte[7]) begin
      state_next.data_count = 1'b0;
      if (rx_byte >= mrsp_pkg::STATUS_SYSEX) begin
        state_next.running_status = (rx_byte == mrsp_pkg::STATUS_SONG_POS) ?
                                    rx_byte : mrsp_pkg::STATUS_NONE;
      end else begin
        state_next.running_status = rx_byte;
      end
    end else if (state.running_status != mrsp_pkg::STATUS_NONE && need != 2'd0) begin
      if (!state.data_count) begin
        if (need == 2'd1) begin
          msg.valid  = 1'b1;
          msg.data1  = rx_byte[6:0];
          msg.length = mrsp_pkg::LEN_TWO;
        end else begin
          state_next.first_data = rx_byte[6:0];
          state_next.data_count = 1'b1;
        end
      end else begin
        msg.valid  = 1'b1;
        msg.data1  = state.first_data;
        msg.data2  = rx_byte[6:0];
        msg.length = mrsp_pkg::LEN_THREE;
        state_next.data_count = 1'b0;
        // song position does not run on
        if (state.running_status >= mrsp_pkg::STATUS_SYSEX) begin
          state_next.running_status = mrsp_pkg::STATUS_NONE;
        end
      end
    end
    msg.accepted = mrsp_pkg::chan_accepts(msg.status, filter);
  end

endmodule

// ===== hdl/midi_running_status_parser_top.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status parser
// Assembles MIDI messages from a received byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while rx_stall is low, also while a waiting
// message is taken, and gives the completed message in a result register in
// the cycle after the byte that completes it. Throughput is set by the single
// decode stage between the parser state and the result register: rx_stall
// rises only while a message is held and msg_stall is high. Realtime bytes
// come out as one-byte messages; other status bytes and incomplete data give
// no message. The user must write channel_filter only while the parser is
// idle; the block does not check this, and resets it to accept all channels.
module midi_running_status_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              msg_valid,
  input  logic              msg_stall,
  output logic [7:0]        msg_status,
  output logic [6:0]        msg_data1,
  output logic [6:0]        msg_data2,
  output logic [1:0]        msg_length,
  output logic              channel_accepted,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [4:0] channel_filter
);

  mrsp_pkg::state_t state;
  mrsp_pkg::state_t state_next;
  mrsp_pkg::msg_t   msg_next;
  mrsp_pkg::msg_t   msg;
  logic signed [4:0] filter;
  logic             rx_take;

  assign cfg_ready = 1'b1;
  assign rx_stall  = msg.valid && msg_stall;
  assign rx_take   = rx_valid && !rx_stall;

  mrsp_decode u_decode (
    .rx_byte    (rx_byte),
    .state      (state),
    .filter     (filter),
    .state_next (state_next),
    .msg        (msg_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter <= mrsp_pkg::FILTER_ALL;
    end else if (cfg_valid && cfg_ready) begin
      filter <= channel_filter;
    end
  end

  // first_data is left alone in reset; it is always written before use
  always_ff @(posedge clk) begin
    if (rst) begin
      state.running_status <= mrsp_pkg::STATUS_NONE;
      state.data_count     <= 1'b0;
    end else if (rx_take) begin
      state <= state_next;
    end
  end

  // result register: load on a new beat, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      msg.valid <= 1'b0;
    end else if (rx_take) begin
      msg.valid <= msg_next.valid;
      if (msg_next.valid) begin
        msg.status   <= msg_next.status;
        msg.data1    <= msg_next.data1;
        msg.data2    <= msg_next.data2;
        msg.length   <= msg_next.length;
        msg.accepted <= msg_next.accepted;
      end
    end else if (!msg_stall) begin
      msg.valid <= 1'b0;
    end
  end

  assign msg_valid        = msg.valid;
  assign msg_status       = msg.status;
  assign msg_data1        = msg.data1;
  assign msg_data2        = msg.data2;
  assign msg_length       = msg.length;
  assign channel_accepted = msg.accepted;

`ifndef SYNTHESIS
  a_rt_len_one: assert property (@(posedge clk) disable iff (rst)
    msg.valid |-> ((msg.length == mrsp_pkg::LEN_ONE) ==
                   (msg.status >= mrsp_pkg::STATUS_RT_FIRST)))
    else $error("one-byte message without realtime status");

  a_two_byte_kind: assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.length == mrsp_pkg::LEN_TWO) |->
      (msg.data2 == 7'd0 && (msg.status[7:4] == mrsp_pkg::KIND_PROG ||
                             msg.status[7:4] == mrsp_pkg::KIND_PRESSURE)))
    else $error("two-byte message with wrong status kind");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    state.running_status == mrsp_pkg::STATUS_NONE ||
    (state.running_status[7] && state.running_status < mrsp_pkg::STATUS_RT_FIRST))
    else $error("running status holds a non-status byte");

  a_count_needs_status: assert property (@(posedge clk) disable iff (rst)
    state.data_count |-> (state.running_status != mrsp_pkg::STATUS_NONE))
    else $error("data counted with no running status");

  a_msg_hold: assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg_stall) |=> (msg.valid && $stable(msg.status)))
    else $error("stalled message lost or changed");
`endif

endmodule
